### sv/gwrr_pkg.sv
// ----------------------------------------------------------------------------
// gwrr_pkg
// Shared constants and helpers for the grid wavefront relaxation block.
// ----------------------------------------------------------------------------
package gwrr_pkg;
  localparam int GridSide = 16;
  localparam int CoordW   = $clog2(GridSide);
  localparam int Cells    = GridSide * GridSide * GridSide;
  localparam int AddrW    = 3 * CoordW;
  localparam int Mid      = GridSide / 2;

  localparam logic [7:0] Unreached = 8'd255;
  localparam logic [7:0] SatMax    = 8'd254;
  localparam logic [7:0] PeakReset = 8'd58;

  localparam logic [1:0] ActStep = 2'd0;
  localparam logic [1:0] ActRead = 2'd1;
  localparam logic [1:0] ActInit = 2'd2;

  // 2*|c-mid|+1
  function automatic logic [7:0] offset_of(input logic [CoordW-1:0] c);
    logic [7:0] d;
    d = (32'(c) > Mid) ? 8'(32'(c) - Mid) : 8'(Mid - 32'(c));
    return 8'((d << 1) + 8'd1);
  endfunction

  // saturating offer value
  function automatic logic [7:0] offer_val(input logic [7:0] r, input logic [7:0] off);
    logic [8:0] s;
    s = 9'(r) + 9'(off);
    return (s > 9'(SatMax)) ? SatMax : s[7:0];
  endfunction
endpackage

### sv/gwrr_ram.sv
// ----------------------------------------------------------------------------
// gwrr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module gwrr_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/gwrr_pulse.sv
// ----------------------------------------------------------------------------
// gwrr_pulse
// Triangle pulse phase counter.
// ----------------------------------------------------------------------------
module gwrr_pulse (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] peak,
  output logic [7:0] phase
);
  logic       down;
  logic [7:0] phase_next;
  logic       down_next;

  always_comb begin
    phase_next = phase;
    down_next  = down;
    if (!down) begin
      if (phase < peak) begin
        phase_next = phase + 8'd1;
      end else begin
        down_next = 1'b1;
        if (phase != 8'd0) phase_next = phase - 8'd1;
      end
    end else begin
      if (phase != 8'd0) begin
        phase_next = phase - 8'd1;
      end else begin
        down_next = 1'b0;
        if (peak != 8'd0) phase_next = 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 8'd0;
      down  <= 1'b0;
    end else if (advance) begin
      phase <= phase_next;
      down  <= down_next;
    end
  end
endmodule

### sv/gwrr_ctrl.sv
// ----------------------------------------------------------------------------
// gwrr_ctrl
// Sequencer: clearing sweep, copy and relaxation passes over a ping-pong pair of
// radius memories, active-flag pass, and cell reads.
// ----------------------------------------------------------------------------
module gwrr_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                action,
  input  logic [3:0]                cell_x,
  input  logic [3:0]                cell_y,
  input  logic [3:0]                cell_z,
  input  logic [7:0]                phase,
  output logic                      advance,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                cell_radius_sq,
  output logic                      cell_active
);
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StCopy  = 3'd2;
  localparam logic [2:0] StRelax = 3'd3;
  localparam logic [2:0] StFlag  = 3'd4;
  localparam logic [2:0] StRead  = 3'd5;
  localparam logic [2:0] StRdW   = 3'd6;
  localparam logic [2:0] StOut   = 3'd7;

  localparam int AW = gwrr_pkg::AddrW;
  localparam int CW = gwrr_pkg::CoordW;
  localparam logic [AW-1:0] CenterAddr =
    AW'((gwrr_pkg::Mid * gwrr_pkg::GridSide + gwrr_pkg::Mid) * gwrr_pkg::GridSide
        + gwrr_pkg::Mid);
  localparam logic [AW-1:0] LastAddr = AW'(gwrr_pkg::Cells - 1);

  logic [2:0]    state;
  logic          cur;      // bank holding current radius
  logic [AW-1:0] cnt;      // cell sweep counter
  logic [2:0]    sub;      // relax sub-step: 0 read self, 7 self data, 1..6 neighbours
  logic [7:0]    self_r;
  logic [AW-1:0] rd_addr;
  logic          oob;
  logic          has_item; // clear sweep was started by an accepted word

  // bank memories
  logic          we [2];
  logic [AW-1:0] waddr [2];
  logic [7:0]    wdata [2];
  logic [AW-1:0] raddr [2];
  logic [7:0]    rdata [2];
  logic          act_we;
  logic [AW-1:0] act_waddr;
  logic          act_wdata;
  logic [AW-1:0] act_raddr;
  logic          act_rdata;

  // relaxation pipeline: pending neighbour update (read issued last cycle)
  logic          pend;
  logic          pend_wait;
  logic [AW-1:0] pend_addr;
  logic [7:0]    pend_val;

  logic [CW-1:0] cx, cy, cz;
  logic [AW-1:0] nb_addr;
  logic          nb_ok;
  logic [7:0]    nb_off;
  logic [7:0]    min_v;
  logic [7:0]    fwd_old;

  assign cx = cnt[AW-1 -: CW];
  assign cy = cnt[CW +: CW];
  assign cz = cnt[CW-1:0];

  always_comb begin
    nb_addr = cnt;
    nb_ok   = 1'b0;
    nb_off  = 8'd0;
    case (sub)
      3'd1: begin
        nb_ok = 32'(cx) + 1 < gwrr_pkg::GridSide;
        nb_addr = {cx + CW'(1), cy, cz};
        nb_off = gwrr_pkg::offset_of(cx);
      end
      3'd2: begin
        nb_ok = cx != '0; nb_addr = {cx - CW'(1), cy, cz};
        nb_off = gwrr_pkg::offset_of(cx);
      end
      3'd3: begin
        nb_ok = 32'(cy) + 1 < gwrr_pkg::GridSide;
        nb_addr = {cx, cy + CW'(1), cz};
        nb_off = gwrr_pkg::offset_of(cy);
      end
      3'd4: begin
        nb_ok = cy != '0; nb_addr = {cx, cy - CW'(1), cz};
        nb_off = gwrr_pkg::offset_of(cy);
      end
      3'd5: begin
        nb_ok = 32'(cz) + 1 < gwrr_pkg::GridSide;
        nb_addr = {cx, cy, cz + CW'(1)};
        nb_off = gwrr_pkg::offset_of(cz);
      end
      3'd6: begin
        nb_ok = cz != '0; nb_addr = {cx, cy, cz - CW'(1)};
        nb_off = gwrr_pkg::offset_of(cz);
      end
      default: ;
    endcase
  end

  // pending update: old next-bank value vs offer; updates serialize, the next
  // read being issued only after the previous write, so it sees that write (no overlap).
  assign fwd_old = rdata[~cur];
  assign min_v   = (pend_val < fwd_old) ? pend_val : fwd_old;

  logic [7:0] diff;
  assign diff = (rdata[~cur] > phase) ? rdata[~cur] - phase : phase - rdata[~cur];

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      we[b] = 1'b0; waddr[b] = cnt; wdata[b] = rdata[b]; raddr[b] = cnt;
    end
    act_we = 1'b0; act_waddr = cnt; act_wdata = 1'b0; act_raddr = rd_addr;
    raddr[cur] = rd_addr;
    case (state)
      StClear: begin
        we[cur] = 1'b1;
        wdata[cur] = (cnt == CenterAddr) ? 8'd0 : gwrr_pkg::Unreached;
        act_we = 1'b1;
      end
      StCopy: begin
        raddr[cur] = cnt;
        we[~cur] = sub[0];
        waddr[~cur] = pend_addr;
        wdata[~cur] = rdata[cur];
      end
      StRelax: begin
        raddr[cur] = cnt;
        raddr[~cur] = nb_addr;
        we[~cur] = pend;
        waddr[~cur] = pend_addr;
        wdata[~cur] = (pend_addr == CenterAddr) ? 8'd0 : min_v;
      end
      StFlag: begin
        raddr[~cur] = cnt;
        act_we = sub[0];
        act_waddr = pend_addr;
        act_wdata = (rdata[~cur] != gwrr_pkg::Unreached) && (diff <= 8'd1);
      end
      default: ;
    endcase
  end

  for (genvar b = 0; b < 2; b++) begin : g_bank
    gwrr_ram #(.Width(8), .Depth(gwrr_pkg::Cells)) u_r (
      .clk, .we(we[b]), .waddr(waddr[b]), .wdata(wdata[b]),
      .raddr(raddr[b]), .rdata(rdata[b])
    );
  end
  gwrr_ram #(.Width(1), .Depth(gwrr_pkg::Cells)) u_act (
    .clk, .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
    .raddr(act_raddr), .rdata(act_rdata)
  );

  assign in_ready = (state == StIdle);
  assign advance  = in_ready && in_valid && (action == gwrr_pkg::ActStep);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StClear; cnt <= '0; cur <= 1'b0; sub <= '0; pend <= 1'b0;
      pend_wait <= 1'b0; has_item <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        StClear: begin
          cnt <= cnt + AW'(1);
          if (cnt == LastAddr) state <= has_item ? StRead : StIdle;
        end
        StIdle: if (in_valid) begin
          rd_addr <= {cell_x[CW-1:0], cell_y[CW-1:0], cell_z[CW-1:0]};
          oob <= (32'(cell_x) >= gwrr_pkg::GridSide) || (32'(cell_y) >= gwrr_pkg::GridSide)
                 || (32'(cell_z) >= gwrr_pkg::GridSide);
          cnt <= '0; sub <= '0; pend <= 1'b0; pend_wait <= 1'b0;
          has_item <= 1'b1;
          case (action)
            gwrr_pkg::ActStep: state <= StCopy;
            gwrr_pkg::ActInit: state <= StClear;
            default:           state <= StRead;
          endcase
        end
        StCopy: begin
          // sub[0]=0: read issued; sub[0]=1: write
          sub <= {2'b0, ~sub[0]};
          pend_addr <= cnt;
          if (sub[0]) begin
            cnt <= cnt + AW'(1);
            if (cnt == LastAddr) begin
              cnt <= '0; sub <= '0; state <= StRelax;
            end
          end
        end
        StRelax: begin
          // sub 0: read self; 7: self data; then, for a reached cell, per neighbour:
          // read cycle (odd phase) and write cycle.
          pend <= 1'b0;
          if (sub == 3'd0) begin
            sub <= 3'd7;
          end else if (sub == 3'd7) begin
            self_r <= rdata[cur];
            if (rdata[cur] == gwrr_pkg::Unreached) begin
              cnt <= cnt + AW'(1); sub <= 3'd0;
              if (cnt == LastAddr) begin
                cnt <= '0; state <= StFlag;
              end
            end else begin
              sub <= 3'd1;
            end
          end else if (!pend && !pend_wait) begin
            pend_wait <= 1'b1;
            if (nb_ok) begin
              pend_addr <= nb_addr;
              pend_val  <= gwrr_pkg::offer_val(self_r, nb_off);
              pend <= 1'b1;
            end
          end else begin
            pend_wait <= 1'b0;
            if (sub == 3'd6) begin
              sub <= 3'd0; cnt <= cnt + AW'(1);
              if (cnt == LastAddr) begin
                cnt <= '0; state <= StFlag;
              end
            end else begin
              sub <= sub + 3'd1;
            end
          end
        end
        StFlag: begin
          sub <= {2'b0, ~sub[0]};
          pend_addr <= cnt;
          if (sub[0]) begin
            cnt <= cnt + AW'(1);
            if (cnt == LastAddr) begin
              cur <= ~cur; state <= StRead;
            end
          end
        end
        StRead: state <= StRdW;
        StRdW: begin
          cell_radius_sq <= oob ? gwrr_pkg::Unreached : rdata[cur];
          cell_active    <= oob ? 1'b0 : act_rdata;
          out_valid <= 1'b1;
          state <= StOut;
        end
        StOut: if (out_ready) begin
          out_valid <= 1'b0; state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule

### sv/grid_wavefront_radius_relaxation.sv
// ----------------------------------------------------------------------------
// grid_wavefront_radius_relaxation
// Top level: pulse counter, config register and grid sequencer.
// ----------------------------------------------------------------------------
// One word in, one word out. A read or unused action passes through the read,
// read-wait and output states; an init sweeps the grid one cell a cycle (also
// run after reset with input held off) and then returns a read. A step copies
// the grid (a read and then a write per cell), relaxes it (fetching each cell's
// value, plus a read slot and a write slot for each of the six neighbour slots
// of a reached cell, one write port on the next-value memory) and rewrites the
// active flags (a read and a write per cell).
module grid_wavefront_radius_relaxation (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] pulse_peak,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [3:0] cell_x,
  input  logic [3:0] cell_y,
  input  logic [3:0] cell_z,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] pulse_value,
  output logic [7:0] cell_radius_sq,
  output logic       cell_active
);
  logic [7:0] peak;
  logic       advance;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      peak <= gwrr_pkg::PeakReset;
    end else if (cfg_valid) begin
      peak <= pulse_peak;
    end
  end

  gwrr_pulse u_pulse (.clk, .rst, .advance, .peak, .phase(pulse_value));

  gwrr_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .action, .cell_x, .cell_y, .cell_z,
    .phase(pulse_value), .advance, .out_valid, .out_ready, .cell_radius_sq,
    .cell_active
  );
endmodule

### sv/gwrr_checker.sv
// ----------------------------------------------------------------------------
// gwrr_checker
// Port-level checks for the grid relaxation block.
// ----------------------------------------------------------------------------
module gwrr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] pulse_value,
  input logic [7:0] cell_radius_sq
);
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken with result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_radius_sq))
    else $error("result dropped");
  a_pulse_step: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready) |=> $stable(pulse_value))
    else $error("pulse moved without an item");
endmodule

bind grid_wavefront_radius_relaxation gwrr_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .pulse_value,
  .cell_radius_sq
);
